@@ hdl/ehs_pkg.sv @@
package ehs_pkg;

  localparam int TIMER_BITS = 16;
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  localparam int ADDR_BITS = 5;

  localparam logic [2:0] REG_FAST_TORQUE   = 3'd0;
  localparam logic [2:0] REG_SLOW_TORQUE   = 3'd1;
  localparam logic [2:0] REG_SETTLE_TICKS  = 3'd2;
  localparam logic [2:0] REG_BACKOFF_TICKS = 3'd3;
  localparam logic [2:0] REG_CENTER_TICKS  = 3'd4;

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_FAST_SEEK    = 4'd1;
  localparam logic [3:0] PH_SETTLE_1     = 4'd2;
  localparam logic [3:0] PH_BACKOFF      = 4'd3;
  localparam logic [3:0] PH_SETTLE_2     = 4'd4;
  localparam logic [3:0] PH_SLOW_SEEK    = 4'd5;
  localparam logic [3:0] PH_SETTLE_3     = 4'd6;
  localparam logic [3:0] PH_CENTER       = 4'd7;
  localparam logic [3:0] PH_FINAL_SETTLE = 4'd8;

  typedef struct packed {
    logic [14:0] fast_torque;
    logic [14:0] slow_torque;
    logic [15:0] settle_ticks;
    logic [15:0] backoff_ticks;
    logic [15:0] center_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic        done_res;
    logic        busy_res;
    logic        zero_encoder;
    logic [15:0] linear_torque;
  } res_t;

  function automatic logic [TIMER_BITS-1:0] eff_ticks(input logic [15:0] r_val);
    logic [31:0] wide;
    wide = 32'(r_val);
    if (wide == 32'd0) begin
      wide = 32'd1;
    end
    if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return wide[TIMER_BITS-1:0];
  endfunction

endpackage

@@ hdl/ehs_cfg_regs.sv @@
module ehs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ehs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ehs_pkg::cfg_t                 cfg
);
  import ehs_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_torque   <= 15'd256;
      cfg.slow_torque   <= 15'd128;
      cfg.settle_ticks  <= 16'd100;
      cfg.backoff_ticks <= 16'd500;
      cfg.center_ticks  <= 16'd2000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FAST_TORQUE:   cfg.fast_torque   <= pwdata[14:0];
        REG_SLOW_TORQUE:   cfg.slow_torque   <= pwdata[14:0];
        REG_SETTLE_TICKS:  cfg.settle_ticks  <= pwdata[15:0];
        REG_BACKOFF_TICKS: cfg.backoff_ticks <= pwdata[15:0];
        REG_CENTER_TICKS:  cfg.center_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAST_TORQUE:   prdata = {17'd0, cfg.fast_torque};
      REG_SLOW_TORQUE:   prdata = {17'd0, cfg.slow_torque};
      REG_SETTLE_TICKS:  prdata = {16'd0, cfg.settle_ticks};
      REG_BACKOFF_TICKS: prdata = {16'd0, cfg.backoff_ticks};
      REG_CENTER_TICKS:  prdata = {16'd0, cfg.center_ticks};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/ehs_step.sv @@
module ehs_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          start_req,
  input  logic          endstop_level,
  input  ehs_pkg::cfg_t cfg,
  output ehs_pkg::res_t res
);
  import ehs_pkg::*;

  logic [3:0]            phase_reg;
  logic [3:0]            phase_reg_next;
  logic [TIMER_BITS-1:0] tick_count;
  logic [TIMER_BITS-1:0] tick_count_next;

  always_comb begin
    logic [3:0]            ph;
    logic [TIMER_BITS-1:0] cnt;
    logic [TIMER_BITS-1:0] dur;
    logic [TIMER_BITS:0]   cnt_inc;
    logic                  timed;
    logic                  pressed;

    pressed = !endstop_level;
    ph      = (phase_reg > PH_FINAL_SETTLE) ? PH_IDLE : phase_reg;
    cnt     = tick_count;
    if (ph == PH_IDLE && start_req) begin
      ph  = PH_FAST_SEEK;
      cnt = '0;
    end
    if (ph == PH_FAST_SEEK && pressed) begin
      ph  = PH_SETTLE_1;
      cnt = '0;
    end
    if (ph == PH_SLOW_SEEK && pressed) begin
      ph  = PH_SETTLE_3;
      cnt = '0;
    end

    res.linear_torque = 16'd0;
    res.zero_encoder  = 1'b0;
    dur               = eff_ticks(cfg.settle_ticks);
    case (ph)
      PH_FAST_SEEK: res.linear_torque = 16'd0 - {1'b0, cfg.fast_torque};
      PH_SLOW_SEEK: res.linear_torque = 16'd0 - {1'b0, cfg.slow_torque};
      PH_BACKOFF: begin
        res.linear_torque = {1'b0, cfg.fast_torque};
        dur               = eff_ticks(cfg.backoff_ticks);
      end
      PH_CENTER: begin
        res.linear_torque = {1'b0, cfg.fast_torque};
        res.zero_encoder  = (cnt == '0);
        dur               = eff_ticks(cfg.center_ticks);
      end
      default: ;
    endcase

    timed   = ph inside {PH_SETTLE_1, PH_BACKOFF, PH_SETTLE_2, PH_SETTLE_3,
                         PH_CENTER, PH_FINAL_SETTLE};
    cnt_inc = {1'b0, cnt} + 1'b1;

    phase_reg_next  = ph;
    tick_count_next = cnt;
    res.done_res    = 1'b0;
    if (timed) begin
      if (cnt_inc >= {1'b0, dur}) begin
        tick_count_next = '0;
        if (ph == PH_FINAL_SETTLE) begin
          phase_reg_next = PH_IDLE;
          res.done_res   = 1'b1;
        end else begin
          phase_reg_next = ph + 4'd1;
        end
      end else begin
        tick_count_next = cnt_inc[TIMER_BITS-1:0];
      end
    end

    res.busy_res = (ph != PH_IDLE);
    res.phase    = ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= PH_IDLE;
      tick_count <= '0;
    end else if (advance) begin
      phase_reg  <= phase_reg_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

@@ hdl/endstop_homing_sequencer_core.sv @@
// Endstop homing sequencer for one linear axis.
// Feed one transaction per millisecond tick on s_axis: start request and raw
// endstop level (low is pressed). Each input transaction yields exactly one
// result transaction on m_axis: Q8.8 torque for the tick, encoder zero pulse,
// busy, done pulse and the phase executed.
// A start while idle runs fast seek, settle, backoff, settle, slow seek,
// settle, centering (zero pulse on its first tick) and a final settle.
// Phase durations and torque magnitudes come from the APB registers, which the
// user must write only while no transaction is in flight; the block does not enforce this.
// An input is captured in the input register and its result in the result
// register, which drives m_axis; back-pressure can hold it in either.
// Throughput: one transaction per cycle while m_axis_tready is high; the
// phase/tick state update sits between the two registers.
// Reset clears the phase to idle, the tick counter and both stage valids, and
// loads the register defaults. When m_axis_tready is low the result holds,
// one more input is held in the input register, then s_axis_tready drops.
module endstop_homing_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] start_req, [1] endstop_level
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] linear_torque, [16] zero_encoder, [17] busy_res, [18] done_res, [22:19] phase
  output logic [23:0]                   m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ehs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ehs_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_valid;
  logic [1:0] in_data;
  logic       out_valid;
  res_t       out_res;
  logic       advance;

  ehs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata[1:0];
    end
  end

  ehs_step u_step (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .start_req     (in_data[0]),
    .endstop_level (in_data[1]),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

endmodule

@@ hdl/ehs_checker.sv @@
module ehs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import ehs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[17] == (m_axis_tdata[22:19] != PH_IDLE))
    else $error("busy disagrees with phase");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[22:19] == PH_FINAL_SETTLE
      && m_axis_tdata[15:0] == 16'd0)
    else $error("done outside final settle");

  a_zero_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[22:19] == PH_CENTER
      && !m_axis_tdata[15])
    else $error("encoder zero outside centering");

endmodule

bind endstop_homing_sequencer_core ehs_checker u_ehs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_endstop_homing_sequencer_core.sv @@
module tb_endstop_homing_sequencer_core;
  import ehs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SETS           = 12;
  localparam int TICKS_PER_SET  = 128;
  localparam int EXTREME_ROW    = 5;
  localparam int ROWS           = 19;

  typedef struct packed {
    logic start;
    logic level;
    logic typed;
    res_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [0] start_req, [1] endstop_level
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [15:0] linear_torque, [16] zero_encoder, [17] busy_res, [18] done_res, [22:19] phase
  logic [23:0]          m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  res_t        tick_results_q[$];
  cfg_t        regs_q;
  logic [3:0]  phase_q;
  logic [15:0] tick_cnt_q;
  int          mismatches;
  int          idle_cycles;
  int          stall_left;
  bit          quiet;

  // start, level, typed, {phase, done, busy, zero, torque}
  row_t dir_rows [ROWS] = '{
    {1'b0, 1'b1, 1'b1, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 1'b1, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b1, 1'b1, 1'b1, PH_FAST_SEEK,    1'b0, 1'b1, 1'b0, 16'hFF00},
    {1'b1, 1'b1, 1'b1, PH_FAST_SEEK,    1'b0, 1'b1, 1'b0, 16'hFF00},
    {1'b0, 1'b0, 1'b1, PH_SETTLE_1,     1'b0, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b1, PH_SETTLE_1,     1'b0, 1'b1, 1'b0, 16'h0000},
    {1'b1, 1'b1, 1'b1, PH_BACKOFF,      1'b0, 1'b1, 1'b0, 16'h7FFF},
    {1'b0, 1'b0, 1'b1, PH_SETTLE_2,     1'b0, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b1, PH_SLOW_SEEK,    1'b0, 1'b1, 1'b0, 16'h8001},
    {1'b0, 1'b0, 1'b1, PH_SETTLE_3,     1'b0, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b1, PH_CENTER,       1'b0, 1'b1, 1'b1, 16'h7FFF},
    {1'b0, 1'b1, 1'b1, PH_FINAL_SETTLE, 1'b1, 1'b1, 1'b0, 16'h0000},
    {1'b1, 1'b0, 1'b1, PH_SETTLE_1,     1'b0, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 1'b0, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b0, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 1'b0, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b0, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b0, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b1, 1'b1, PH_IDLE,         1'b0, 1'b0, 1'b0, 16'h0000}
  };

  endstop_homing_sequencer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [16:0] phase_len(input logic [15:0] ticks);
    return (ticks == 16'd0) ? 17'd1 : {1'b0, ticks};
  endfunction

  function automatic res_t homing_tick(input logic start, input logic level);
    logic [3:0]  ph;
    logic [15:0] cnt;
    logic [16:0] dur;
    res_t        r;
    ph  = phase_q;
    cnt = tick_cnt_q;
    dur = '0;
    r   = '0;
    if (ph > PH_FINAL_SETTLE) ph = PH_IDLE;
    if (ph == PH_IDLE && start) begin
      ph  = PH_FAST_SEEK;
      cnt = '0;
    end
    if (ph == PH_FAST_SEEK && !level) begin
      ph  = PH_SETTLE_1;
      cnt = '0;
    end
    if (ph == PH_SLOW_SEEK && !level) begin
      ph  = PH_SETTLE_3;
      cnt = '0;
    end
    case (ph)
      PH_FAST_SEEK: r.linear_torque = 16'd0 - {1'b0, regs_q.fast_torque};
      PH_SLOW_SEEK: r.linear_torque = 16'd0 - {1'b0, regs_q.slow_torque};
      PH_BACKOFF: begin
        r.linear_torque = {1'b0, regs_q.fast_torque};
        dur = phase_len(regs_q.backoff_ticks);
      end
      PH_CENTER: begin
        r.linear_torque = {1'b0, regs_q.fast_torque};
        r.zero_encoder  = (cnt == 16'd0);
        dur = phase_len(regs_q.center_ticks);
      end
      PH_SETTLE_1, PH_SETTLE_2, PH_SETTLE_3, PH_FINAL_SETTLE: begin
        dur = phase_len(regs_q.settle_ticks);
      end
      default: ;
    endcase
    r.phase    = ph;
    r.busy_res = (ph != PH_IDLE);
    phase_q    = ph;
    tick_cnt_q = cnt;
    if (dur != 17'd0) begin
      if ({1'b0, cnt} + 17'd1 >= dur) begin
        tick_cnt_q = '0;
        if (ph == PH_FINAL_SETTLE) begin
          phase_q    = PH_IDLE;
          r.done_res = 1'b1;
        end else begin
          phase_q = ph + 4'd1;
        end
      end else begin
        tick_cnt_q = cnt + 16'd1;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    want = '0;
    case (idx)
      REG_FAST_TORQUE: begin
        regs_q.fast_torque = val[14:0];
        want = {17'd0, val[14:0]};
      end
      REG_SLOW_TORQUE: begin
        regs_q.slow_torque = val[14:0];
        want = {17'd0, val[14:0]};
      end
      REG_SETTLE_TICKS: begin
        regs_q.settle_ticks = val[15:0];
        want = {16'd0, val[15:0]};
      end
      REG_BACKOFF_TICKS: begin
        regs_q.backoff_ticks = val[15:0];
        want = {16'd0, val[15:0]};
      end
      REG_CENTER_TICKS: begin
        regs_q.center_ticks = val[15:0];
        want = {16'd0, val[15:0]};
      end
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("prdata", want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(input logic start, input logic level, input logic typed,
                           input res_t want);
    int   gap;
    res_t r;
    gap = quiet ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, level, start};
    do @(posedge clk); while (!s_axis_tready);
    r = homing_tick(start, level);
    tick_results_q.push_back(typed ? want : r);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[22:0]);
        if (tick_results_q.size() == 0) begin
          $display("%0t: result with nothing pending, got %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("linear_torque", 32'(want.linear_torque), 32'(got.linear_torque));
          check_field("zero_encoder", 32'(want.zero_encoder), 32'(got.zero_encoder));
          check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("phase", 32'(want.phase), 32'(got.phase));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [14:0] ft;
    logic [14:0] st;
    logic [15:0] se;
    logic [15:0] bo;
    logic [15:0] ce;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    quiet         = 1'b0;
    phase_q       = PH_IDLE;
    tick_cnt_q    = '0;
    regs_q.fast_torque   = 15'd256;
    regs_q.slow_torque   = 15'd128;
    regs_q.settle_ticks  = 16'd100;
    regs_q.backoff_ticks = 16'd500;
    regs_q.center_ticks  = 16'd2000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROWS; i++) begin
      if (i == EXTREME_ROW) begin
        wait_drained();
        reg_write(REG_FAST_TORQUE, 32'hFFFF_FFFF);
        reg_write(REG_SLOW_TORQUE, 32'hFFFF_FFFF);
        reg_write(REG_SETTLE_TICKS, 32'hFFFF_0000);
        reg_write(REG_BACKOFF_TICKS, 32'h0001_0000);
        reg_write(REG_CENTER_TICKS, 32'h0000_0000);
      end
      send_tick(dir_rows[i].start, dir_rows[i].level, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int s = 0; s < SETS; s++) begin
      ft = 15'($urandom());
      st = 15'($urandom());
      se = 16'($urandom_range(0, 5));
      bo = 16'($urandom_range(0, 8));
      ce = (s == 7) ? 16'($urandom_range(20, 60)) : 16'($urandom_range(0, 8));
      case (s)
        0: begin
          se = 16'hFFFF;
          bo = 16'hFFFF;
          ce = 16'hFFFF;
        end
        1: begin
          ft = '0;
          st = '0;
          se = '0;
          bo = '0;
          ce = '0;
        end
        2: begin
          ft = 15'h7FFF;
          st = 15'h7FFF;
          se = 16'd1;
          bo = 16'd1;
          ce = 16'd1;
        end
        default: ;
      endcase
      wait_drained();
      quiet = (s % 4 == 3);
      reg_write(REG_FAST_TORQUE, {17'($urandom()), ft});
      reg_write(REG_SLOW_TORQUE, {17'($urandom()), st});
      reg_write(REG_SETTLE_TICKS, {16'($urandom()), se});
      reg_write(REG_BACKOFF_TICKS, {16'($urandom()), bo});
      reg_write(REG_CENTER_TICKS, {16'($urandom()), ce});
      for (int n = 0; n < TICKS_PER_SET; n++) begin
        logic start;
        logic level;
        if (s == 5 && n == TICKS_PER_SET / 2) wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          start = 1'($urandom());
          level = 1'($urandom());
        end else begin
          case (phase_q)
            PH_IDLE: begin
              start = ($urandom_range(0, 2) != 0);
              level = ($urandom_range(0, 3) != 0);
            end
            PH_FAST_SEEK, PH_SLOW_SEEK: begin
              start = ($urandom_range(0, 7) == 0);
              level = ($urandom_range(0, 5) != 0);
            end
            default: begin
              start = ($urandom_range(0, 7) == 0);
              level = ($urandom_range(0, 3) != 0);
            end
          endcase
        end
        send_tick(start, level, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
